// ===== hw/rtl/mmaf_pkg.sv =====
`timescale 1ns / 1ps

package mmaf_pkg;

    // Width of one sample and of one filtered value.
    localparam int SAMPLE_W = 12;
    // Distance channels carried by one beat, ahead of the motor current field.
    localparam int DIST_CH = 6;
    // Raw window length, split into three groups of three.
    localparam int WINDOW_LEN = 9;
    localparam int FIELDS = DIST_CH + 1;
    localparam int FIELD_BITS = FIELDS * SAMPLE_W;
    localparam int TDATA_W = ((FIELD_BITS + 7) / 8) * 8;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Pipeline advance strobes shared by all lanes.
    typedef struct packed {
        logic load;   // beat accepted: windows shift, group medians captured
        logic step;   // stage 1 moves into stage 2: history shifts
        logic emit;   // stage 2 moves into the output register
    } mmaf_adv_t;

    // Median of three. Equal values give that value.
    function automatic sample_t mid3(sample_t x, sample_t y, sample_t z);
        sample_t lo;
        sample_t hi;
        sample_t res;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        if (z <= lo)
        begin
            res = lo;
        end
        else if (z >= hi)
        begin
            res = hi;
        end
        else
        begin
            res = z;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/mmaf_lane.sv =====
`timescale 1ns / 1ps

module mmaf_lane #(
    parameter int AVERAGE_TAPS = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mmaf_pkg::mmaf_adv_t adv,
    input  mmaf_pkg::sample_t   sample,
    output mmaf_pkg::sample_t   filtered
);
    import mmaf_pkg::*;

    localparam int TAP_L = $clog2(AVERAGE_TAPS);
    localparam int HSUM_W = SAMPLE_W + TAP_L;
    localparam int DIV_SH = HSUM_W + TAP_L;
    localparam int RECIP_W = HSUM_W + 1;
    localparam int PROD_W = HSUM_W + RECIP_W;
    localparam longint unsigned RECIP_VAL =
        ((longint'(1) << DIV_SH) + AVERAGE_TAPS - 1) / AVERAGE_TAPS;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    sample_t               window_reg [WINDOW_LEN];
    sample_t               grp_reg [3];
    sample_t               hist_reg [AVERAGE_TAPS];
    logic [HSUM_W-1:0]     hsum_reg;
    logic [HSUM_W-1:0]     hsum_next;
    sample_t               pmed;
    sample_t               filtered_reg;
    logic [PROD_W-1:0]     prod;

    // Raw window, newest first. Reset to zero as the filter starts from rest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW_LEN; k++)
            begin
                window_reg[k] <= '0;
            end
        end
        else if (adv.load)
        begin
            window_reg[0] <= sample;
            for (int k = 1; k < WINDOW_LEN; k++)
            begin
                window_reg[k] <= window_reg[k-1];
            end
        end
    end

    // Group medians of the window as it stands after this sample enters.
    always_ff @(posedge clk)
    begin
        if (adv.load)
        begin
            grp_reg[0] <= mid3(sample, window_reg[0], window_reg[1]);
            grp_reg[1] <= mid3(window_reg[2], window_reg[3], window_reg[4]);
            grp_reg[2] <= mid3(window_reg[5], window_reg[6], window_reg[7]);
        end
    end

    assign pmed = mid3(grp_reg[0], grp_reg[1], grp_reg[2]);
    assign hsum_next = hsum_reg + HSUM_W'(pmed) - HSUM_W'(hist_reg[AVERAGE_TAPS-1]);

    // History of pseudo-medians with a running sum kept alongside.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AVERAGE_TAPS; k++)
            begin
                hist_reg[k] <= '0;
            end
            hsum_reg <= '0;
        end
        else if (adv.step)
        begin
            hist_reg[0] <= pmed;
            for (int k = 1; k < AVERAGE_TAPS; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
            hsum_reg <= hsum_next;
        end
    end

    // Division by the tap count as a multiply by a rounded-up reciprocal.
    assign prod = PROD_W'(hsum_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (adv.emit)
        begin
            filtered_reg <= prod[DIV_SH +: SAMPLE_W];
        end
    end

    assign filtered = filtered_reg;

endmodule

// ===== hw/rtl/median_of_medians_average_filter.sv =====
`timescale 1ns / 1ps
// Pseudo-median-of-nine filter with moving average for six distance sensors,
// plus a nine-sample moving average of motor current.
// Slave channel: one beat carries one new sample for every sensor; s_tdata
// holds seven 12-bit fields from the lowest bit up (see port comment).
// Master channel: one beat per input beat, in the same order, carrying the
// six filtered distances and the averaged current in the same layout.
// Pipeline: the group medians are captured on the edge that accepts an input
// beat, the median of medians enters the history as that beat moves into the
// second stage, and the reciprocal multiply that divides each running sum
// fills the output register, which drives m_tvalid, as the beat moves on
// from the second stage.
// Throughput is one beat per cycle while the receiver holds m_tready high.
// When the receiver stalls, each stage holds its beat and s_tready stays
// high for as long as any stage is free, so up to three beats are absorbed
// before the input is held off.
// Reset clears every window, history and running sum to zero, so outputs
// ramp up from zero over the first beats. No clearing pass is needed.
module median_of_medians_average_filter #(
    parameter int AVERAGE_TAPS = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // front_low_sample, front_up_sample, front_left_sample,
    // front_right_sample, side_right_sample, side_left_sample,
    // motor_current_sample, then zero padding
    input  logic [mmaf_pkg::TDATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // front_low_filtered, front_up_filtered, front_left_filtered,
    // front_right_filtered, side_right_filtered, side_left_filtered,
    // motor_current_average, then zero padding
    output logic [mmaf_pkg::TDATA_W-1:0]   m_tdata
);
    import mmaf_pkg::*;

    // Current channel divide-by-nine constants.
    localparam int WIN_L = $clog2(WINDOW_LEN);
    localparam int CSUM_W = SAMPLE_W + WIN_L;
    localparam int CDIV_SH = CSUM_W + WIN_L;
    localparam int CRECIP_W = CSUM_W + 1;
    localparam int CPROD_W = CSUM_W + CRECIP_W;
    localparam longint unsigned CRECIP_VAL =
        ((longint'(1) << CDIV_SH) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [CRECIP_W-1:0] CRECIP = CRECIP_W'(CRECIP_VAL);

    mmaf_adv_t            adv;
    logic                 st1_valid_reg;
    logic                 st2_valid_reg;
    logic                 out_valid_reg;
    logic                 out_ready;
    logic                 st2_ready;
    logic                 st1_ready;

    sample_t              cur_sample;
    sample_t              cur_win_reg [WINDOW_LEN];
    logic [CSUM_W-1:0]    cur_sum_reg;
    logic [CSUM_W-1:0]    cur_sum_next;
    logic [CSUM_W-1:0]    cur_s2_reg;
    logic [CPROD_W-1:0]   cur_prod;
    sample_t              cur_avg_reg;
    logic [CSUM_W-1:0]    cur_chk;

    sample_t              dist_out [DIST_CH];

    // Each stage moves on when the one after it is empty or moving on too.
    assign out_ready = !out_valid_reg || m_tready;
    assign st2_ready = !st2_valid_reg || out_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign s_tready  = st1_ready;

    assign adv.load = s_tvalid && st1_ready;
    assign adv.step = st1_valid_reg && st2_ready;
    assign adv.emit = st2_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (st1_ready)
            begin
                st1_valid_reg <= s_tvalid;
            end
            if (st2_ready)
            begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= st2_valid_reg;
            end
        end
    end

    // One lane per distance sensor.
    for (genvar ch = 0; ch < DIST_CH; ch++)
    begin : g_lane
        mmaf_lane #(
            .AVERAGE_TAPS (AVERAGE_TAPS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .sample   (s_tdata[ch*SAMPLE_W +: SAMPLE_W]),
            .filtered (dist_out[ch])
        );
    end

    // Motor current: plain moving average over the raw window, kept as a
    // running sum so that only one add and one subtract sit in the path.
    assign cur_sample   = s_tdata[DIST_CH*SAMPLE_W +: SAMPLE_W];
    assign cur_sum_next = cur_sum_reg + CSUM_W'(cur_sample)
                          - CSUM_W'(cur_win_reg[WINDOW_LEN-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW_LEN; k++)
            begin
                cur_win_reg[k] <= '0;
            end
            cur_sum_reg <= '0;
        end
        else if (adv.load)
        begin
            cur_win_reg[0] <= cur_sample;
            for (int k = 1; k < WINDOW_LEN; k++)
            begin
                cur_win_reg[k] <= cur_win_reg[k-1];
            end
            cur_sum_reg <= cur_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.step)
        begin
            cur_s2_reg <= cur_sum_reg;
        end
    end

    assign cur_prod = CPROD_W'(cur_s2_reg) * CPROD_W'(CRECIP);

    always_ff @(posedge clk)
    begin
        if (adv.emit)
        begin
            cur_avg_reg <= cur_prod[CDIV_SH +: SAMPLE_W];
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata = '0;
        for (int ch = 0; ch < DIST_CH; ch++)
        begin
            m_tdata[ch*SAMPLE_W +: SAMPLE_W] = dist_out[ch];
        end
        m_tdata[DIST_CH*SAMPLE_W +: SAMPLE_W] = cur_avg_reg;
    end

    // Sum of the current window, recomputed for checking the running sum.
    always_comb
    begin
        cur_chk = '0;
        for (int k = 0; k < WINDOW_LEN; k++)
        begin
            cur_chk = cur_chk + CSUM_W'(cur_win_reg[k]);
        end
    end

    a_cur_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cur_sum_reg == cur_chk)
        else $error("current running sum out of step with its window");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input held off while the output register is empty");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> st1_valid_reg)
        else $error("accepted beat did not reach the first stage");

    a_st2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        st2_valid_reg && !out_ready |=> st2_valid_reg)
        else $error("second stage lost a beat while the output stalled");

endmodule

// ===== tb/sv/median_of_medians_average_filter_test.sv =====
`timescale 1ns / 1ps

module median_of_medians_average_filter_test;

    import mmaf_pkg::*;

    // History depth of the moving average; the DUT is built with the same value.
    localparam int AVG_TAPS = 6;
    // Beats that go in before the random part stops.
    localparam int TOTAL_BEATS = 1650;
    // Beats at the end of the run with no idling on either side.
    localparam int QUIET_BEATS = 150;
    // A wide margin over the slowest correct run before the run is declared hung.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles to wait after the last expected beat.
    localparam int DRAIN_CYCLES = 12;

    // One beat viewed as seven 12-bit fields, the first field in the lowest bits.
    typedef logic [FIELDS-1:0][SAMPLE_W-1:0] sample_set_t;

    // Shapes of random content used for the sequences of beats.
    typedef enum int {
        MODE_UNIFORM,   // independent values over the whole range
        MODE_EXTREME,   // only zero and full scale
        MODE_CLUSTER,   // values close to a level, with the odd spike
        MODE_RAMP       // values that climb or fall steadily
    } stim_mode_t;

    // The scoreboard keeps its own copy of the filter state. Every accepted
    // input beat advances that state and queues the result it must produce;
    // every accepted output beat is then checked against the oldest entry.
    class filter_scoreboard;
        sample_t     dist_window [DIST_CH][WINDOW_LEN];
        sample_t     median_hist [DIST_CH][AVG_TAPS];
        sample_t     current_window [WINDOW_LEN];
        sample_set_t expected_q [$];
        string       field_names [FIELDS];
        int          errors;

        function new();
            foreach (dist_window[ch, k])
            begin
                dist_window[ch][k] = '0;
            end
            foreach (median_hist[ch, k])
            begin
                median_hist[ch][k] = '0;
            end
            foreach (current_window[k])
            begin
                current_window[k] = '0;
            end
            field_names = '{"front_low_filtered", "front_up_filtered",
                            "front_left_filtered", "front_right_filtered",
                            "side_right_filtered", "side_left_filtered",
                            "motor_current_average"};
            errors = 0;
        endfunction

        // Middle value of three; with two or three equal values it is that value.
        function sample_t median_of_three(sample_t a, sample_t b, sample_t c);
            if ((a >= b && a <= c) || (a <= b && a >= c))
            begin
                return a;
            end
            if ((b >= a && b <= c) || (b <= a && b >= c))
            begin
                return b;
            end
            return c;
        endfunction

        function void note_input(sample_set_t beat);
            sample_set_t result;
            sample_t     grp [3];
            sample_t     pseudo_median;
            int unsigned sum;
            int          ch;
            int          k;

            for (ch = 0; ch < DIST_CH; ch++)
            begin
                for (k = WINDOW_LEN - 1; k > 0; k--)
                begin
                    dist_window[ch][k] = dist_window[ch][k-1];
                end
                dist_window[ch][0] = beat[ch];
                // Newest, middle and oldest groups of three.
                for (k = 0; k < 3; k++)
                begin
                    grp[k] = median_of_three(dist_window[ch][3*k],
                                             dist_window[ch][3*k+1],
                                             dist_window[ch][3*k+2]);
                end
                pseudo_median = median_of_three(grp[0], grp[1], grp[2]);
                for (k = AVG_TAPS - 1; k > 0; k--)
                begin
                    median_hist[ch][k] = median_hist[ch][k-1];
                end
                median_hist[ch][0] = pseudo_median;
                sum = 0;
                for (k = 0; k < AVG_TAPS; k++)
                begin
                    sum += median_hist[ch][k];
                end
                result[ch] = sample_t'(sum / AVG_TAPS);
            end

            for (k = WINDOW_LEN - 1; k > 0; k--)
            begin
                current_window[k] = current_window[k-1];
            end
            current_window[0] = beat[DIST_CH];
            sum = 0;
            for (k = 0; k < WINDOW_LEN; k++)
            begin
                sum += current_window[k];
            end
            result[DIST_CH] = sample_t'(sum / WINDOW_LEN);

            expected_q.push_back(result);
        endfunction

        function void check_result(sample_set_t got);
            sample_set_t want;
            int          f;

            if (expected_q.size() == 0)
            begin
                $error("output beat %h arrived with no result outstanding", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            for (f = 0; f < FIELDS; f++)
            begin
                if (got[f] !== want[f])
                begin
                    $error("%s: expected %0d, got %0d", field_names[f], want[f], got[f]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;

    filter_scoreboard    sb;
    // Set for the closing part of the run, where neither side idles.
    bit                  quiet;
    int                  cycles;

    median_of_medians_average_filter #(
        .AVERAGE_TAPS(AVG_TAPS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Every output beat is checked at the rising edge on which it is taken.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata[FIELDS*SAMPLE_W-1:0]);
        end
    end

    // Receiver: ready most of the time, with stalls dropped in at random until
    // the quiet part of the run.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Offers one beat and holds it until the DUT takes it. The task is entered
    // and left at a falling edge, so s_tvalid stays high across back-to-back
    // beats and is only lowered for a deliberate gap.
    task automatic send_beat(input sample_set_t beat);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - FIELDS*SAMPLE_W){1'b0}}, beat};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_input(beat);
        @(negedge clk);
    endtask

    initial
    begin
        sample_set_t beat;
        stim_mode_t  mode;
        int          level [FIELDS];
        int          slope [FIELDS];
        int          sent;
        int          run_len;
        int          paused;
        int          i;
        int          f;
        int          v;

        sb       = new();
        quiet    = 1'b0;
        paused   = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full scale on every field from reset: the windows and histories fill
        // from zero, so the outputs climb and reach full scale well before the
        // last of these beats.
        for (i = 0; i < 16; i++)
        begin
            for (f = 0; f < FIELDS; f++)
            begin
                beat[f] = 12'hFFF;
            end
            send_beat(beat);
        end
        // A short run of zeros: too short to pull the pseudo-median down.
        for (i = 0; i < 3; i++)
        begin
            send_beat('0);
        end
        // Alternating bit patterns give groups of three with two equal values.
        for (i = 0; i < 6; i++)
        begin
            for (f = 0; f < FIELDS; f++)
            begin
                beat[f] = ((i + f) % 2 != 0) ? 12'hAAA : 12'h555;
            end
            send_beat(beat);
        end
        sent = 25;

        for (f = 0; f < FIELDS; f++)
        begin
            level[f] = $urandom_range(0, 4095);
        end

        // Random part: sequences of beats that share a shape, so the windows
        // see steady levels, steps, ramps and isolated spikes, not only noise.
        while (sent < TOTAL_BEATS)
        begin
            mode    = stim_mode_t'($urandom_range(0, 3));
            run_len = $urandom_range(4, 40);
            for (f = 0; f < FIELDS; f++)
            begin
                slope[f] = $urandom_range(0, 128) - 64;
            end
            for (i = 0; i < run_len && sent < TOTAL_BEATS; i++)
            begin
                for (f = 0; f < FIELDS; f++)
                begin
                    case (mode)
                        MODE_UNIFORM:
                        begin
                            v = $urandom_range(0, 4095);
                        end
                        MODE_EXTREME:
                        begin
                            v = ($urandom_range(0, 1) != 0) ? 4095 : 0;
                        end
                        MODE_CLUSTER:
                        begin
                            if ($urandom_range(0, 7) == 0)
                            begin
                                v = $urandom_range(0, 4095);
                            end
                            else
                            begin
                                v = level[f] + $urandom_range(0, 8) - 4;
                            end
                        end
                        default:
                        begin
                            v = level[f] + slope[f];
                            level[f] = v;
                        end
                    endcase
                    if (v < 0)
                    begin
                        v = 0;
                    end
                    if (v > 4095)
                    begin
                        v = 4095;
                    end
                    level[f] = (mode == MODE_CLUSTER) ? level[f] : v;
                    beat[f]  = sample_t'(v);
                end
                send_beat(beat);
                sent++;

                // Once, halfway through, let the pipeline run completely dry.
                if (paused == 0 && sent >= TOTAL_BEATS / 2)
                begin
                    paused = 1;
                    s_tvalid <= 1'b0;
                    while (sb.pending() != 0)
                    begin
                        @(negedge clk);
                    end
                end
                if (sent >= TOTAL_BEATS - QUIET_BEATS)
                begin
                    quiet = 1'b1;
                end
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        // A few more cycles so that any stray extra beat is caught.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mmaf_pkg.sv
hw/rtl/mmaf_lane.sv
hw/rtl/median_of_medians_average_filter.sv
tb/sv/median_of_medians_average_filter_test.sv
